// ===== hdl/rhpt_pkg.sv =====
// ---------------------------------------------------------------------------
// rhpt_pkg
// shared constants, types and build-time functions for the rolling hash trigger
// ---------------------------------------------------------------------------
package rhpt_pkg;

    localparam int RHPT_WINDOW_SIZE = 10;
    localparam int SYM_W            = 8;
    localparam int HASH_W           = 31;
    localparam int MOD_W            = 31;
    localparam int OUT_DATA_W       = 40;   // hash, full, trigger, zero pad

    localparam logic [HASH_W-1:0] KR_PRIME      = 31'd1999999973;
    localparam logic [MOD_W-1:0]  MODULUS_RESET = 31'd100;

    // control word for the shared modular step unit
    typedef struct packed {
        logic              load;      // acc <= load_val
        logic [HASH_W-1:0] load_val;
        logic              step;      // acc <= reduce(acc * (dbl ? 2 : 1) + addend)
        logic              dbl;
        logic [HASH_W-1:0] addend;
        logic [HASH_W-1:0] divisor;
    } t_step_ctl;

    // 256^(w-1) mod prime, eight doublings with a conditional subtract per byte
    function automatic logic [HASH_W-1:0] kr_base_power(input int w);
        logic [HASH_W:0] acc;
        acc = (HASH_W+1)'(1);
        for (int i = 1; i < w; i++) begin
            for (int b = 0; b < 8; b++) begin
                acc = {acc[HASH_W-1:0], 1'b0};
                if (acc >= {1'b0, KR_PRIME}) begin
                    acc = acc - {1'b0, KR_PRIME};
                end
            end
        end
        return acc[HASH_W-1:0];
    endfunction

    // coefficient folding the removal of the oldest byte into the horner pass:
    // prime - (256 * 256^(w-1) mod prime), reduced below the prime
    function automatic logic [HASH_W-1:0] kr_remove_coef(input int w);
        logic [HASH_W:0] q;
        logic [HASH_W:0] k;
        q = {1'b0, kr_base_power(w)};
        for (int b = 0; b < 8; b++) begin
            q = {q[HASH_W-1:0], 1'b0};
            if (q >= {1'b0, KR_PRIME}) begin
                q = q - {1'b0, KR_PRIME};
            end
        end
        k = {1'b0, KR_PRIME} - q;
        if (k == {1'b0, KR_PRIME}) begin
            k = '0;
        end
        return k[HASH_W-1:0];
    endfunction

endpackage

// ===== hdl/rhpt_ram.sv =====
// ---------------------------------------------------------------------------
// rhpt_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module rhpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rhpt_modstep.sv =====
// ---------------------------------------------------------------------------
// rhpt_modstep
// shared accumulator with one double-add-reduce step per cycle while step is set
// ---------------------------------------------------------------------------
module rhpt_modstep
    import rhpt_pkg::*;
(
    input  logic              i_clk,
    input  t_step_ctl         i_ctl,
    output logic [HASH_W-1:0] o_acc
);

    logic [HASH_W-1:0] r_acc;
    logic [HASH_W+1:0] w_sum;
    logic [HASH_W+1:0] w_d1;
    logic [HASH_W+1:0] w_d2;
    logic [HASH_W+1:0] w_red;

    // sum stays below twice the divisor plus one divisor, so at most 2*d comes off
    always_comb begin
        w_sum = (i_ctl.dbl ? {1'b0, r_acc, 1'b0} : {2'b00, r_acc})
              + {2'b00, i_ctl.addend};
        w_d1  = {2'b00, i_ctl.divisor};
        w_d2  = {1'b0, i_ctl.divisor, 1'b0};
        if (w_sum >= w_d2) begin
            w_red = w_sum - w_d2;
        end else if (w_sum >= w_d1) begin
            w_red = w_sum - w_d1;
        end else begin
            w_red = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= i_ctl.load_val;
        end else if (i_ctl.step) begin
            r_acc <= w_red[HASH_W-1:0];
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hdl/rolling_hash_phrase_trigger.sv =====
// ---------------------------------------------------------------------------
// rolling_hash_phrase_trigger
// karp-rabin rolling hash over a byte window with a phrase boundary trigger
// ---------------------------------------------------------------------------
// usage:
//   input stream: one byte per item in s_tdata[7:0]; s_tuser set restarts the
//   window (ring, hash and fill count cleared) before that byte is taken
//   output stream: one item per input item, m_tdata holds the hash of the
//   window modulo 1999999973, the window-full flag and the trigger flag
//   trigger is set when the window is full and the hash is a multiple of the
//   modulus written through the cfg port (zero modulus never triggers)
// sequence:
//   the item is accepted, its oldest byte read from the ring ram, then the
//   shared modular step unit runs 8 horner steps (shift by one bit of the
//   removed byte), one step to add the new byte and 31 restoring steps of the
//   trigger remainder; the result goes to the output register and s_tready
//   returns with it, so the next item is taken only once the last one's
//   result is in the output register
// reset and stall:
//   reset empties the window and sets the modulus to 100
//   the output register holds a result until m_tready; the next item is taken
//   meanwhile and its computation waits in the last state for the register
// ---------------------------------------------------------------------------
module rolling_hash_phrase_trigger
    import rhpt_pkg::*;
#(
    parameter int WINDOW_SIZE = RHPT_WINDOW_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SYM_W-1:0]      i_s_tdata,    // [7:0] symbol
    input  logic                  i_s_tuser,    // [0] start_req
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,    // [30:0] hash_value, [31] window_full,
                                                // [32] trigger, [39:33] zero
    // configuration
    input  logic                  i_cfg_we,
    input  logic [MOD_W-1:0]      i_cfg_wdata   // trigger_modulus
);

    localparam int PW = $clog2(WINDOW_SIZE);
    localparam int FW = $clog2(WINDOW_SIZE + 1);
    localparam logic [PW-1:0]     POS_LAST  = PW'(WINDOW_SIZE - 1);
    localparam logic [FW-1:0]     FILL_MAX  = FW'(WINDOW_SIZE);
    localparam logic [HASH_W-1:0] REM_COEF  = kr_remove_coef(WINDOW_SIZE);
    localparam logic [4:0]        HRN_LAST  = 5'd7;
    localparam logic [4:0]        DIV_LAST  = 5'(HASH_W - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_LD   = 3'd2;
    localparam logic [2:0] S_HRN  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_SAVE = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [4:0]             r_cnt, n_cnt;
    logic [PW-1:0]          r_pos, n_pos;
    logic [FW-1:0]          r_fill, n_fill;
    logic [WINDOW_SIZE-1:0] r_valid, n_valid;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [MOD_W-1:0]       r_modulus;
    logic [SYM_W-1:0]       r_sym;
    logic [SYM_W-1:0]       r_old;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_full;
    logic                   w_trig;
    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [SYM_W-1:0]       w_ram_rdata;
    logic [HASH_W-1:0]      w_acc;
    t_step_ctl              w_ctl;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_fill == FILL_MAX);
    // remainder sits in the accumulator after the last restoring step
    assign w_trig     = w_full && (r_modulus != '0) && (w_acc == '0);
    assign w_ram_re   = (r_state == S_RD);
    assign w_ram_we   = (r_state == S_LD);

    // ring of the last bytes, read at the oldest slot before it is overwritten
    rhpt_ram #(
        .WIDTH (SYM_W),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_sym),
        .i_re    (w_ram_re),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    rhpt_modstep u_step (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_acc (w_acc)
    );

    // step unit control per state
    always_comb begin
        w_ctl          = '0;
        w_ctl.divisor  = KR_PRIME;
        case (r_state)
            S_LD: begin
                w_ctl.load     = 1'b1;
                w_ctl.load_val = r_hash;
            end
            S_HRN: begin
                // acc = 2*acc + bit * coef, most significant bit of old byte first
                w_ctl.step   = 1'b1;
                w_ctl.dbl    = 1'b1;
                w_ctl.addend = r_old[3'd7 - r_cnt[2:0]] ? REM_COEF : '0;
            end
            S_ADD: begin
                w_ctl.step   = 1'b1;
                w_ctl.addend = {{(HASH_W-SYM_W){1'b0}}, r_sym};
            end
            S_SAVE: begin
                w_ctl.load = 1'b1;
            end
            S_DIV: begin
                // restoring remainder of the hash by the modulus, one bit a step
                w_ctl.step    = 1'b1;
                w_ctl.dbl     = 1'b1;
                w_ctl.addend  = {{(HASH_W-1){1'b0}}, r_hash[DIV_LAST - r_cnt]};
                w_ctl.divisor = r_modulus;
            end
            default: begin
                w_ctl.step = 1'b0;
            end
        endcase
    end

    // sequencer and window bookkeeping
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_valid     = r_valid;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RD;
                    if (i_s_tuser) begin
                        n_pos   = '0;
                        n_fill  = '0;
                        n_valid = '0;
                        n_hash  = '0;
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_state        = S_HRN;
                n_cnt          = '0;
                n_valid[r_pos] = 1'b1;
                n_pos          = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                if (r_fill != FILL_MAX) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            S_HRN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == HRN_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = S_SAVE;
            end
            S_SAVE: begin
                n_state = S_DIV;
                n_cnt   = '0;
                n_hash  = w_acc;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_valid     <= '0;
            r_hash      <= '0;
            r_modulus   <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_valid     <= n_valid;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym <= i_s_tdata;
        end
        if (r_state == S_LD) begin
            // slot never written since the last clear reads as zero
            r_old <= r_valid[r_pos] ? w_ram_rdata : '0;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= {{(OUT_DATA_W-HASH_W-2){1'b0}}, w_trig, w_full, r_hash};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/rhpt_checker.sv =====
// ---------------------------------------------------------------------------
// rhpt_checker
// port-level checks for the rolling hash trigger, bound to the top level
// ---------------------------------------------------------------------------
module rhpt_checker
    import rhpt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output item changed");

    // one item at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item accepted while busy");

    // hash is always reduced below the prime
    a_hash_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[HASH_W-1:0] < KR_PRIME))
        else $error("hash not reduced");

    // trigger only with a full window, pad bits zero
    a_trig_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((!o_m_tdata[32] || o_m_tdata[31]) && (o_m_tdata[39:33] == '0)))
        else $error("trigger without full window or bad padding");

endmodule

bind rolling_hash_phrase_trigger rhpt_checker u_rhpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the rolling hash phrase trigger: a short directed
// run, then random byte streams across several trigger moduli, with every
// output item compared against a predicted hash, full flag and trigger flag
// ---------------------------------------------------------------------------
module testbench;
    import rhpt_pkg::*;

    localparam int              WIN        = RHPT_WINDOW_SIZE;
    localparam longint unsigned HASH_PRIME = longint'(KR_PRIME);
    localparam int              N_PHASES   = 12;
    localparam int              PHASE_LEN  = 90;

    // expected fields of one output item
    typedef struct {
        logic [HASH_W-1:0] hash;
        logic              full;
        logic              trig;
    } t_window_result;

    // tracks the window, predicts each output item and compares it
    class t_phrase_checker;
        logic [SYM_W-1:0]  ring [WIN];
        int unsigned       oldest_slot;
        int unsigned       fill;
        logic [HASH_W-1:0] hash;
        logic [MOD_W-1:0]  modulus;
        longint unsigned   drop_weight;
        t_window_result    due_results [$];
        int                mismatches;
        int                checked;
        int                triggers;
        int                full_windows;

        function new();
            drop_weight = 1;
            // weight of the oldest byte: 256^(WIN-1) mod prime
            for (int i = 1; i < WIN; i++) begin
                drop_weight = (drop_weight * 256) % HASH_PRIME;
            end
            clear_window();
            modulus      = MODULUS_RESET;
            mismatches   = 0;
            checked      = 0;
            triggers     = 0;
            full_windows = 0;
        endfunction

        function void clear_window();
            foreach (ring[i]) ring[i] = '0;
            oldest_slot = 0;
            fill        = 0;
            hash        = '0;
        endfunction

        function void set_modulus(logic [MOD_W-1:0] m);
            modulus = m;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // roll the window by one accepted byte and queue the expected item
        function void note_symbol(logic [SYM_W-1:0] sym, logic start);
            longint unsigned removed;
            longint unsigned h;
            int unsigned     slot;
            t_window_result  r;
            if (start) clear_window();
            slot = oldest_slot;
            if (slot >= WIN) slot = 0;
            if (fill < WIN) fill++;
            removed = (longint'(ring[slot]) * drop_weight) % HASH_PRIME;
            h = (longint'(hash) % HASH_PRIME) + HASH_PRIME - removed;
            h = (256 * h + longint'(sym)) % HASH_PRIME;
            hash = HASH_W'(h);
            ring[slot] = sym;
            slot++;
            if (slot >= WIN) slot = 0;
            oldest_slot = slot;
            r.hash = hash;
            r.full = (fill == WIN);
            r.trig = 1'b0;
            // zero modulus never triggers and no division happens
            if (r.full && modulus != 0) r.trig = ((hash % modulus) == 0);
            due_results.insert(due_results.size(), r);
        endfunction

        function void report(string what, string want, string got);
            if (mismatches < 10) begin
                $display("mismatch on output item %0d, %s: expected %s, got %s",
                         checked, what, want, got);
            end
            mismatches++;
        endfunction

        function void check_output(logic [OUT_DATA_W-1:0] data);
            t_window_result want;
            if (due_results.size() == 0) begin
                report("unexpected item", "none", $sformatf("%h", data));
                return;
            end
            want = due_results.pop_front();
            if (data[HASH_W-1:0] !== want.hash)
                report("hash_value", $sformatf("%0d", want.hash),
                       $sformatf("%0d", data[HASH_W-1:0]));
            if (data[HASH_W] !== want.full)
                report("window_full", $sformatf("%b", want.full),
                       $sformatf("%b", data[HASH_W]));
            if (data[HASH_W+1] !== want.trig)
                report("trigger", $sformatf("%b", want.trig),
                       $sformatf("%b", data[HASH_W+1]));
            if (want.trig) triggers++;
            if (want.full) full_windows++;
            checked++;
        endfunction
    endclass

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  o_s_tready;
    logic [SYM_W-1:0]      s_data;
    logic                  s_user;
    logic                  o_m_tvalid;
    logic                  rx_ready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  cfg_we;
    logic [MOD_W-1:0]      cfg_data;

    // no idling on either side while set
    logic                  calm = 1'b0;

    t_phrase_checker       chk = new();
    int                    sent = 0;
    int                    leftover;
    logic [MOD_W-1:0]      moduli [N_PHASES];

    rolling_hash_phrase_trigger dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),      // [7:0] symbol
        .i_s_tuser   (s_user),      // [0] start_req
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (rx_ready),
        .o_m_tdata   (o_m_tdata),   // [30:0] hash, [31] full, [32] trigger
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver: random backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        rx_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // every accepted output item is checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && rx_ready) chk.check_output(o_m_tdata);
    end

    // hands one byte to the block, random gaps first; called at a falling edge
    task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic start);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= sym;
        s_user  <= start;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        chk.note_symbol(sym, start);
        sent++;
        @(negedge i_clk);
    endtask

    // stop sending and wait until every predicted item has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // modulus change only while the block is idle
    task automatic write_modulus(input logic [MOD_W-1:0] m);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        chk.set_modulus(m);
    endtask

    // one random run: mostly random bytes, rare restarts, some zero bursts
    task automatic random_run(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 3) begin
                // a full window of zeros hashes to zero and triggers unless the modulus is zero
                for (int k = 0; k < WIN; k++) push_symbol('0, 1'b0);
                n += WIN;
            end else begin
                push_symbol(($urandom_range(99) < 8) ? SYM_W'(0)
                                                     : SYM_W'($urandom_range(255)),
                            $urandom_range(99) < 3);
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        s_user   = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset modulus of 100
        // cleared window filled with zeros: hash zero at full, trigger
        push_symbol(8'h00, 1'b1);
        for (int k = 1; k < WIN; k++) push_symbol(8'h00, 1'b0);
        // zeros rolling out, largest byte in
        push_symbol(8'hff, 1'b0);
        push_symbol(8'hff, 1'b0);
        // restart in the middle of a window, then all largest bytes
        push_symbol(8'hff, 1'b1);
        for (int k = 1; k < WIN; k++) push_symbol(8'hff, 1'b0);
        push_symbol(8'h80, 1'b0);
        push_symbol(8'h55, 1'b0);

        // random phases, the extremes and the odd moduli among them
        moduli[0]  = 31'd10;
        moduli[1]  = 31'h7fff_ffff;
        moduli[2]  = 31'd0;            // zero modulus never triggers
        moduli[3]  = 31'd1;            // modulus one, every full window triggers
        moduli[4]  = 31'd7;
        moduli[5]  = 31'd2;
        moduli[6]  = MOD_W'($urandom_range(1000, 10));
        moduli[7]  = MOD_W'($urandom() & 32'h7fff_ffff);
        moduli[8]  = KR_PRIME;
        moduli[9]  = 31'd256;
        moduli[10] = MOD_W'($urandom() & 32'h7fff_ffff);
        moduli[11] = MODULUS_RESET;

        for (int p = 0; p < N_PHASES; p++) begin
            write_modulus(moduli[p]);
            calm = (p == 4);
            if (p == 6) begin
                // pause halfway until the block has emptied
                random_run(PHASE_LEN / 2);
                wait_drained();
                random_run(PHASE_LEN / 2);
            end else begin
                random_run(PHASE_LEN);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (60) @(posedge i_clk);
        leftover = chk.pending();
        if (leftover != 0) begin
            $display("%0d predicted output items never arrived", leftover);
        end

        $display("sent %0d bytes over %0d moduli, %0d output items checked",
                 sent, N_PHASES + 1, chk.checked);
        $display("%0d full windows, %0d triggers, %0d mismatches",
                 chk.full_windows, chk.triggers, chk.mismatches);
        if (chk.mismatches == 0 && leftover == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #1000000;
        $display("timeout after %0d bytes", sent);
        $display("FAILURE");
        $finish;
    end

endmodule
